// File: rtl/sdrd_pkg.sv
// Constants, codes and types shared by the record-stream deframer.
package sdrd_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int SIZE_W      = 32;

    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 80;
    localparam int M_TUSER_W   = 5;

    localparam logic [SIZE_W-1:0] LEN_MASK =
        SIZE_W'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [SIZE_W-1:0] SIZE_ONES = '1;

    localparam logic [2:0] PH_FIRST = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_REC   = 3'd2;
    localparam logic [2:0] PH_OCR   = 3'd3;
    localparam logic [2:0] PH_SIZE  = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_END   = 3'd6;
    localparam logic [2:0] PH_STOP  = 3'd7;

    localparam logic [7:0] TYPE_HEADER = 8'h01;
    localparam logic [7:0] TYPE_PAGE   = 8'h02;
    localparam logic [7:0] TYPE_FOOTER = 8'h03;

    localparam logic [1:0] SEG_IMAGE  = 2'd0;
    localparam logic [1:0] SEG_PDF    = 2'd1;
    localparam logic [1:0] SEG_TEXT   = 2'd2;
    localparam logic [1:0] SEG_FOOTER = 2'd3;

    localparam logic [3:0] ST_RUN     = 4'd0;
    localparam logic [3:0] ST_DONE    = 4'd1;
    localparam logic [3:0] ST_EMPTY   = 4'd2;
    localparam logic [3:0] ST_BADTYPE = 4'd3;
    localparam logic [3:0] ST_ZERO    = 4'd4;
    localparam logic [3:0] ST_BADOCR  = 4'd5;
    localparam logic [3:0] ST_TRUNC   = 4'd6;
    localparam logic [3:0] ST_EXTRA   = 4'd7;
    localparam logic [3:0] ST_ONES    = 4'd8;

    typedef struct packed {
        logic              payload_valid;
        logic [7:0]        payload_byte;
        logic [1:0]        segment;
        logic [SIZE_W-1:0] page_number;
        logic              segment_last;
        logic              ocr_valid;
        logic              ocr_flag;
        logic              count_valid;
        logic [SIZE_W-1:0] page_count;
        logic [3:0]        status;
    } res_t;

endpackage

// File: rtl/split_document_record_deframer.sv
// Top level of the record-stream deframer: parser state and registered result.
//
// Takes one word per cycle (a stream byte, or an end mark when s_tuser is 1)
// and returns exactly one result word for each, presented in the cycle after acceptance.
// The parser state and the result register both update at the accepting
// edge, so a new word is taken every cycle while the result register is empty
// or being drained: s_tready = !m_tvalid || m_tready. The first error or the
// clean end of the footer freezes the status; later words still give a result
// carrying only page_count and the frozen status.
module split_document_record_deframer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sdrd_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] stream_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] payload_byte, [39:8] page_number, [40] ocr_flag,
    // [72:41] page_count, [76:73] status, [79:77] zero
    output logic [sdrd_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] payload_valid, [2:1] segment, [3] ocr_valid, [4] count_valid
    output logic [sdrd_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast    // segment_last
);
    import sdrd_pkg::*;

    logic [2:0]        phase_reg, phase_next;
    logic [1:0]        idx_reg, idx_next;
    logic [SIZE_W-1:0] acc_reg, acc_next;
    logic [SIZE_W-1:0] remain_reg, remain_next;
    logic [SIZE_W-1:0] seen_reg, seen_next;
    logic [SIZE_W-1:0] declared_reg, declared_next;
    logic [1:0]        seg_reg, seg_next;
    logic [3:0]        status_reg, status_next;
    logic              ocr_reg, ocr_next;
    logic              m_tvalid_reg;
    res_t              res_reg, res_next;

    logic              accept;
    logic [7:0]        b;
    logic              end_mark;
    logic [SIZE_W-1:0] acc_shift;
    logic [SIZE_W-1:0] remain_dec;
    logic [SIZE_W-1:0] page_inc;
    logic              in_page;

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign b          = s_tdata[7:0];
    assign end_mark   = s_tuser;
    assign acc_shift  = {acc_reg[SIZE_W-9:0], b};
    assign remain_dec = remain_reg - SIZE_W'(1);
    assign page_inc   = seen_reg + SIZE_W'(1);
    assign in_page    = seg_reg != SEG_FOOTER;

    always_comb begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        remain_next   = remain_reg;
        seen_next     = seen_reg;
        declared_next = declared_reg;
        seg_next      = seg_reg;
        status_next   = status_reg;
        ocr_next      = ocr_reg;
        res_next      = '0;

        case (phase_reg)
            PH_FIRST: begin
                if (end_mark) begin
                    status_next = ST_EMPTY;
                    phase_next  = PH_STOP;
                end else if (b == TYPE_HEADER) begin
                    idx_next   = '0;
                    acc_next   = '0;
                    phase_next = PH_COUNT;
                end else if (b == TYPE_FOOTER) begin
                    seg_next   = SEG_FOOTER;
                    idx_next   = '0;
                    acc_next   = '0;
                    phase_next = PH_SIZE;
                end else begin
                    status_next = ST_BADTYPE;
                    phase_next  = PH_STOP;
                end
            end
            PH_COUNT: begin
                if (end_mark) begin
                    status_next = ST_TRUNC;
                    phase_next  = PH_STOP;
                end else begin
                    acc_next = acc_shift;
                    if (idx_reg != 2'd3) begin
                        idx_next = idx_reg + 2'd1;
                    end else begin
                        idx_next = '0;
                        if (acc_shift == SIZE_ONES) begin
                            status_next = ST_ONES;
                            phase_next  = PH_STOP;
                        end else if (acc_shift == '0) begin
                            status_next = ST_ZERO;
                            phase_next  = PH_STOP;
                        end else begin
                            declared_next        = acc_shift;
                            res_next.count_valid = 1'b1;
                            seen_next            = '0;
                            phase_next           = PH_REC;
                        end
                    end
                end
            end
            PH_REC: begin
                if (end_mark) begin
                    status_next = ST_TRUNC;
                    phase_next  = PH_STOP;
                end else if (b == TYPE_FOOTER) begin
                    seg_next   = SEG_FOOTER;
                    idx_next   = '0;
                    acc_next   = '0;
                    phase_next = PH_SIZE;
                end else if (b == TYPE_PAGE && seen_reg < declared_reg) begin
                    res_next.page_number = page_inc;
                    seg_next             = SEG_IMAGE;
                    phase_next           = PH_OCR;
                end else begin
                    status_next = ST_BADTYPE;
                    phase_next  = PH_STOP;
                end
            end
            PH_OCR: begin
                res_next.page_number = page_inc;
                if (end_mark) begin
                    status_next = ST_TRUNC;
                    phase_next  = PH_STOP;
                end else if (b[7:1] == 7'd0) begin
                    ocr_next           = b[0];
                    res_next.ocr_valid = 1'b1;
                    res_next.ocr_flag  = b[0];
                    seg_next           = SEG_IMAGE;
                    idx_next           = '0;
                    acc_next           = '0;
                    phase_next         = PH_SIZE;
                end else begin
                    status_next = ST_BADOCR;
                    phase_next  = PH_STOP;
                end
            end
            PH_SIZE: begin
                if (in_page) begin
                    res_next.page_number = page_inc;
                end
                if (end_mark) begin
                    status_next = ST_TRUNC;
                    phase_next  = PH_STOP;
                end else begin
                    acc_next = acc_shift;
                    if (idx_reg != 2'd3) begin
                        idx_next = idx_reg + 2'd1;
                    end else begin
                        idx_next = '0;
                        if (acc_shift == SIZE_ONES || (acc_shift & ~LEN_MASK) != '0) begin
                            status_next = ST_ONES;
                            phase_next  = PH_STOP;
                        end else if (acc_shift == '0) begin
                            if (seg_reg == SEG_TEXT) begin
                                res_next.segment      = SEG_TEXT;
                                res_next.segment_last = 1'b1;
                            end
                            case (seg_reg)
                                SEG_IMAGE: begin
                                    seg_next = SEG_PDF;
                                    acc_next = '0;
                                end
                                SEG_PDF: begin
                                    seg_next = SEG_TEXT;
                                    acc_next = '0;
                                end
                                SEG_TEXT: begin
                                    seen_next  = page_inc;
                                    seg_next   = SEG_IMAGE;
                                    phase_next = PH_REC;
                                end
                                default: begin
                                    phase_next = PH_END;
                                end
                            endcase
                        end else begin
                            remain_next = acc_shift;
                            phase_next  = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA: begin
                if (in_page) begin
                    res_next.page_number = page_inc;
                end
                if (end_mark) begin
                    status_next = ST_TRUNC;
                    phase_next  = PH_STOP;
                end else begin
                    res_next.payload_valid = 1'b1;
                    res_next.payload_byte  = b;
                    res_next.segment       = seg_reg;
                    remain_next            = remain_dec;
                    if (remain_dec == '0) begin
                        res_next.segment_last = 1'b1;
                        case (seg_reg)
                            SEG_IMAGE: begin
                                seg_next   = SEG_PDF;
                                idx_next   = '0;
                                acc_next   = '0;
                                phase_next = PH_SIZE;
                            end
                            SEG_PDF: begin
                                seg_next   = SEG_TEXT;
                                idx_next   = '0;
                                acc_next   = '0;
                                phase_next = PH_SIZE;
                            end
                            SEG_TEXT: begin
                                seen_next  = page_inc;
                                seg_next   = SEG_IMAGE;
                                phase_next = PH_REC;
                            end
                            default: begin
                                phase_next = PH_END;
                            end
                        endcase
                    end
                end
            end
            PH_END: begin
                phase_next  = PH_STOP;
                status_next = end_mark ? ST_DONE : ST_EXTRA;
            end
            default: begin
            end
        endcase

        res_next.page_count = declared_next;
        res_next.status     = status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            idx_reg      <= '0;
            acc_reg      <= '0;
            remain_reg   <= '0;
            seen_reg     <= '0;
            declared_reg <= '0;
            seg_reg      <= SEG_IMAGE;
            status_reg   <= ST_RUN;
            ocr_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg    <= phase_next;
                idx_reg      <= idx_next;
                acc_reg      <= acc_next;
                remain_reg   <= remain_next;
                seen_reg     <= seen_next;
                declared_reg <= declared_next;
                seg_reg      <= seg_next;
                status_reg   <= status_next;
                ocr_reg      <= ocr_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, res_reg.status, res_reg.page_count, res_reg.ocr_flag,
                       res_reg.page_number, res_reg.payload_byte};
    assign m_tuser  = {res_reg.count_valid, res_reg.ocr_valid, res_reg.segment,
                       res_reg.payload_valid};
    assign m_tlast  = res_reg.segment_last;

    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> $onehot0({res_reg.payload_valid, res_reg.ocr_valid,
                                   res_reg.count_valid}))
        else $error("more than one result kind flagged");

    a_status_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        status_reg != ST_RUN |=> status_reg == $past(status_reg))
        else $error("sticky status changed");

    a_payload_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && res_reg.payload_valid |-> res_reg.status == ST_RUN)
        else $error("payload word after stop");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && res_reg.count_valid |-> res_reg.page_count != '0)
        else $error("zero page count accepted");

    a_stop_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        status_reg != ST_RUN |-> phase_reg == PH_STOP)
        else $error("status set while parser runs");

endmodule
